[rtl/pli_pkg.sv]
// package for the positional list block: sizes, codes, request/result types
// and the per-cell control struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int LEN_W    = 5;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_LOAD  = 2'd1;
	localparam logic [1:0] CELL_LEFT  = 2'd2;
	localparam logic [1:0] CELL_RIGHT = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [DATA_W-1:0] read_value;
		logic [LEN_W-1:0]        length;
	} res_t;

	typedef struct packed {
		logic [1:0]              sel;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/pli_cell.sv]
// one list cell: holds a single entry, loads a new value or takes its
// left or right neighbor's entry; depends on pli_pkg
`timescale 1ns / 1ps
`default_nettype none

module pli_cell (
	input  wire logic                        clk,
	input  wire pli_pkg::cell_ctl_t          ctl,
	input  wire logic signed [pli_pkg::DATA_W-1:0] left_data,
	input  wire logic signed [pli_pkg::DATA_W-1:0] right_data,
	output logic signed [pli_pkg::DATA_W-1:0]      data
);

	logic signed [pli_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.sel)
			pli_pkg::CELL_LOAD:  data_q <= ctl.value;
			pli_pkg::CELL_LEFT:  data_q <= left_data;
			pli_pkg::CELL_RIGHT: data_q <= right_data;
			default:             data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

[rtl/positional_list_insert_delete.sv]
// top level of the positional list: request decode, entry count, cell row
// and result register; depends on pli_pkg and pli_cell
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries addressed by 1-based
// position. Requests arrive on req (opcode, position, value) with
// req_valid/req_ready; one result per request leaves on res (status,
// read_value, length) with res_valid/res_ready.
// Insert shifts the cells at and above the position up by one, delete shifts
// the cells above it down by one; every cell moves in the same clock edge.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while res_ready stays high.
// When the receiver stalls, the result is held and req_ready drops until it
// is taken; a request and the draining result may share a cycle.
// Reset clears the entry count and the result valid; cell contents are not
// cleared and only entries below the count are ever read.
// A bad position or unused opcode returns status range, an insert into a
// full list returns status full; neither changes the list.
module positional_list_insert_delete (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire pli_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output pli_pkg::res_t      res
);

	logic [pli_pkg::CNT_W-1:0]          count_q;
	logic                               res_valid_q;
	pli_pkg::res_t                      res_q;
	logic                               accept;
	logic [pli_pkg::CMP_W-1:0]          pos_ext;
	logic [pli_pkg::CMP_W-1:0]          cnt_ext;
	logic [pli_pkg::IDX_W-1:0]          idx;
	logic                               ins_ok;
	logic                               del_ok;
	logic                               rd_ok;
	logic [1:0]                         status_d;
	logic signed [pli_pkg::DATA_W-1:0]  rval_d;
	logic [pli_pkg::CNT_W-1:0]          count_d;
	logic signed [pli_pkg::DATA_W-1:0]  cell_data [pli_pkg::CAPACITY];
	pli_pkg::cell_ctl_t                 cell_ctl  [pli_pkg::CAPACITY];

	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;

	assign pos_ext = pli_pkg::CMP_W'(req.position);
	assign cnt_ext = pli_pkg::CMP_W'(count_q);
	// only used when the position is in range, so it fits the index width
	assign idx     = pli_pkg::IDX_W'(pos_ext - pli_pkg::CMP_W'(1));

	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok    = 1'b0;
		status_d = pli_pkg::ST_RANGE;
		rval_d   = '0;
		count_d  = count_q;
		unique case (req.opcode)
			pli_pkg::OP_INSERT: begin
				if (req.position != '0 && pos_ext <= cnt_ext + pli_pkg::CMP_W'(1)) begin
					if (count_q == pli_pkg::CNT_W'(pli_pkg::CAPACITY)) begin
						status_d = pli_pkg::ST_FULL;
					end else begin
						ins_ok   = 1'b1;
						status_d = pli_pkg::ST_DONE;
						count_d  = count_q + pli_pkg::CNT_W'(1);
					end
				end
			end
			pli_pkg::OP_DELETE, pli_pkg::OP_READ: begin
				if (req.position != '0 && pos_ext <= cnt_ext) begin
					status_d = pli_pkg::ST_DONE;
					rval_d   = cell_data[idx];
					if (req.opcode == pli_pkg::OP_DELETE) begin
						del_ok  = 1'b1;
						count_d = count_q - pli_pkg::CNT_W'(1);
					end else begin
						rd_ok = 1'b1;
					end
				end
			end
			default: begin
				status_d = pli_pkg::ST_RANGE;
			end
		endcase
	end

	for (genvar i = 0; i < pli_pkg::CAPACITY; i++) begin : g_cell
		logic [pli_pkg::IDX_W-1:0]         my_idx;
		logic signed [pli_pkg::DATA_W-1:0] left_d;
		logic signed [pli_pkg::DATA_W-1:0] right_d;

		assign my_idx = pli_pkg::IDX_W'(i);

		always_comb begin
			cell_ctl[i].value = req.value;
			cell_ctl[i].sel   = pli_pkg::CELL_HOLD;
			if (accept && ins_ok) begin
				if (my_idx == idx) begin
					cell_ctl[i].sel = pli_pkg::CELL_LOAD;
				end else if (my_idx > idx) begin
					cell_ctl[i].sel = pli_pkg::CELL_LEFT;
				end
			end else if (accept && del_ok && my_idx >= idx) begin
				cell_ctl[i].sel = pli_pkg::CELL_RIGHT;
			end
		end

		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		// last cell takes its own entry; it falls outside the count anyway
		if (i == pli_pkg::CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		pli_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status     <= status_d;
			res_q.read_value <= rval_d;
			res_q.length     <= pli_pkg::LEN_W'(count_d);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pli_pkg::CNT_W'(pli_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.length == pli_pkg::LEN_W'(count_q))
		else $error("result length differs from entry count");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_d != pli_pkg::ST_DONE) |=> count_q == $past(count_q))
		else $error("failed request changed the entry count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != pli_pkg::ST_DONE) |-> res_q.read_value == '0)
		else $error("failed request returned a nonzero value");

	a_read_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rd_ok) |=> count_q == $past(count_q))
		else $error("read changed the entry count");
`endif

endmodule

`default_nettype wire
